// ===== sv/tng_pkg.sv =====
// ----------------------------------------------------------------------------
// tng_pkg: shared types and constants of the torus neighbor generator
// Sizes, register map, hexagonal port codes, front state and queue control.
// ----------------------------------------------------------------------------
package tng_pkg;

  localparam int DEF_MAX_DIMS   = 4;
  localparam int DEF_INDEX_BITS = 16;

  localparam int RADIX_BITS    = 8;
  localparam int DIMS_BITS     = 3;
  localparam int PORT_BITS     = 3;
  localparam int DIV_STEPS     = RADIX_BITS / 2;
  localparam int QUEUE_DEPTH   = 2;
  localparam int CFG_ADDR_BITS = 4;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [RADIX_BITS-1:0] RADIX_RST = 8'd4;
  localparam logic [DIMS_BITS-1:0]  DIMS_RST  = 3'd2;
  localparam logic                  HEX_RST   = 1'b0;

  localparam logic [1:0] REG_RADIX = 2'd0;
  localparam logic [1:0] REG_DIMS  = 2'd1;
  localparam logic [1:0] REG_HEX   = 2'd2;

  localparam logic [PORT_BITS-1:0] HP_POS_Y  = 3'd0;
  localparam logic [PORT_BITS-1:0] HP_NEG_Y  = 3'd1;
  localparam logic [PORT_BITS-1:0] HP_POS_X  = 3'd2;
  localparam logic [PORT_BITS-1:0] HP_NEG_X  = 3'd3;
  localparam logic [PORT_BITS-1:0] HP_POS_XY = 3'd4;
  localparam logic [PORT_BITS-1:0] HP_NEG_XY = 3'd5;
  localparam logic [PORT_BITS-1:0] HEX_LAST_PORT = HP_NEG_XY;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_WGT,
    FS_DIV,
    FS_PUSH
  } tng_fstate_t;

  typedef struct packed {
    logic hex;
    logic bad;
  } tng_ctl_t;

  function automatic int dim_slots(input int max_dims);
    return (max_dims < 2) ? 2 : max_dims;
  endfunction

  function automatic int port_cnt_bits(input int max_dims);
    int b;
    b = $clog2(2 * dim_slots(max_dims));
    return (b < PORT_BITS) ? PORT_BITS : b;
  endfunction

endpackage

// ===== sv/tng_if.sv =====
// ----------------------------------------------------------------------------
// tng_if: valid/ready channels of the torus neighbor generator
// Node request channel and neighbor result channel.
// ----------------------------------------------------------------------------
interface tng_in_if #(
  parameter int INDEX_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] node_index;

  modport source (output valid, output node_index, input ready);
  modport sink   (input valid, input node_index, output ready);
endinterface

interface tng_out_if #(
  parameter int INDEX_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [2:0]            port;
  logic [INDEX_BITS-1:0] neighbor_index;
  logic                  last;
  logic                  bad_index;

  modport source (output valid, output port, output neighbor_index, output last,
                  output bad_index, input ready);
  modport sink   (input valid, input port, input neighbor_index, input last,
                  input bad_index, output ready);
endinterface

// ===== sv/tng_front.sv =====
// ----------------------------------------------------------------------------
// tng_front: node intake and digit classification
// Builds the place values of each dimension once per configuration, checks
// the node against the network size and extracts its digits two quotient
// bits per cycle, recording for each digit whether it is at the top or the
// bottom of its ring.
// ----------------------------------------------------------------------------
module tng_front
  import tng_pkg::*;
#(
  parameter int MAX_DIMS   = DEF_MAX_DIMS,
  parameter int INDEX_BITS = DEF_INDEX_BITS,
  localparam int D_SLOTS   = dim_slots(MAX_DIMS),
  localparam int PB        = port_cnt_bits(MAX_DIMS)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  tng_in_if.sink                             in_ch,
  input  logic [RADIX_BITS-1:0]              radix,
  input  logic [DIMS_BITS-1:0]               dimensions,
  input  logic                               hex_mode,
  input  logic                               cfg_wr,
  output logic                               ent_valid,
  input  logic                               ent_ready,
  output logic [INDEX_BITS-1:0]              ent_node,
  output tng_ctl_t                           ent_ctl,
  output logic [PB-1:0]                      ent_lastp,
  output logic [D_SLOTS-1:0]                 ent_top,
  output logic [D_SLOTS-1:0]                 ent_zero,
  output logic [D_SLOTS-1:0][INDEX_BITS-1:0] w_o,
  output logic [D_SLOTS-1:0][INDEX_BITS-1:0] rw_o
);

  localparam int IDXB = $clog2(D_SLOTS);
  localparam int NB   = $clog2(D_SLOTS + 1);
  localparam int CW   = INDEX_BITS + RADIX_BITS;
  localparam int SB   = $clog2(DIV_STEPS);

  tng_fstate_t state_r, state_nxt;

  logic [IDXB-1:0]                   idx_r;
  logic [SB-1:0]                     step_r;
  logic [INDEX_BITS-1:0]             node_r;
  logic [INDEX_BITS-1:0]             rem_r;
  logic [CW-1:0]                     dv_r;
  logic [RADIX_BITS-1:0]             digit_r;
  logic [NB-1:0]                     n_r;
  logic                              hex_r;
  logic                              bad_r;
  logic [PB-1:0]                     lastp_r;
  logic                              wok_r;
  logic [D_SLOTS-1:0][INDEX_BITS-1:0] w_r;
  logic [D_SLOTS-1:0][INDEX_BITS-1:0] rw_r;
  logic [D_SLOTS-1:0]                ovf_r;
  logic [INDEX_BITS-1:0]             total_r;
  logic                              tovf_r;
  logic [D_SLOTS-1:0]                top_r;
  logic [D_SLOTS-1:0]                zero_r;

  logic                  in_ready;
  logic                  accept;
  logic [NB-1:0]         n_cfg;
  logic [PB-1:0]         lastp_cfg;
  logic                  bad_in;
  logic [INDEX_BITS-1:0] w_cur;
  logic [CW-1:0]         prod;
  logic [INDEX_BITS-1:0] prod_low;
  logic                  povf;
  logic                  wlast;
  logic                  bad_w;
  logic [CW-1:0]         dsrc;
  logic [CW-1:0]         d2;
  logic [CW-1:0]         d3;
  logic [CW-1:0]         remx;
  logic [CW-1:0]         dsel;
  logic [1:0]            qbits;
  logic [RADIX_BITS-1:0] digit_new;
  logic                  dlast;

  always_comb begin
    if (hex_mode) begin
      n_cfg = NB'(2);
    end else if (dimensions == '0) begin
      n_cfg = NB'(1);
    end else if (int'(dimensions) > MAX_DIMS) begin
      n_cfg = NB'(MAX_DIMS);
    end else begin
      n_cfg = NB'(dimensions);
    end
    if (hex_mode) begin
      lastp_cfg = PB'(HEX_LAST_PORT);
    end else begin
      lastp_cfg = PB'({n_cfg, 1'b0} - (NB + 1)'(1));
    end
  end

  assign bad_in = (radix == '0) || (!tovf_r && (in_ch.node_index >= total_r));

  assign w_cur    = w_r[idx_r];
  assign prod     = CW'(w_cur) * CW'(radix);
  assign prod_low = prod[INDEX_BITS-1:0];
  assign povf     = ovf_r[idx_r] | (|prod[CW-1:INDEX_BITS]);
  assign wlast    = (idx_r == IDXB'(n_r - NB'(1)));
  assign bad_w    = (radix == '0) || (!povf && (node_r >= prod_low));

  always_comb begin
    dsrc  = (step_r == '0) ? (CW'(w_cur) << (RADIX_BITS - 2)) : dv_r;
    d2    = dsrc << 1;
    d3    = dsrc + d2;
    remx  = CW'(rem_r);
    if (ovf_r[idx_r]) begin
      qbits = 2'd0;
      dsel  = '0;
    end else if (remx >= d3) begin
      qbits = 2'd3;
      dsel  = d3;
    end else if (remx >= d2) begin
      qbits = 2'd2;
      dsel  = d2;
    end else if (remx >= dsrc) begin
      qbits = 2'd1;
      dsel  = dsrc;
    end else begin
      qbits = 2'd0;
      dsel  = '0;
    end
    digit_new = {digit_r[RADIX_BITS-3:0], qbits};
    dlast     = (step_r == SB'(DIV_STEPS - 1));
  end

  assign accept = in_ch.valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    ent_valid = 1'b0;
    unique case (state_r)
      FS_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          state_nxt = !wok_r ? FS_WGT : (bad_in ? FS_PUSH : FS_DIV);
        end
      end
      FS_WGT: begin
        if (wlast) begin
          state_nxt = bad_w ? FS_PUSH : FS_DIV;
        end
      end
      FS_DIV: begin
        if (dlast && (idx_r == '0)) begin
          state_nxt = FS_PUSH;
        end
      end
      FS_PUSH: begin
        ent_valid = 1'b1;
        if (ent_ready) begin
          in_ready = 1'b1;
          if (in_ch.valid) begin
            state_nxt = !wok_r ? FS_WGT : (bad_in ? FS_PUSH : FS_DIV);
          end else begin
            state_nxt = FS_IDLE;
          end
        end
      end
      default: state_nxt = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
      wok_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        wok_r <= 1'b0;
      end else if ((state_r == FS_WGT) && wlast) begin
        wok_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      node_r  <= in_ch.node_index;
      rem_r   <= in_ch.node_index;
      hex_r   <= hex_mode;
      n_r     <= n_cfg;
      lastp_r <= lastp_cfg;
      step_r  <= '0;
      if (wok_r) begin
        bad_r <= bad_in;
        idx_r <= IDXB'(n_cfg - NB'(1));
      end else begin
        idx_r    <= '0;
        w_r[0]   <= INDEX_BITS'(1);
        ovf_r[0] <= 1'b0;
      end
    end else if (state_r == FS_WGT) begin
      rw_r[idx_r] <= prod_low - w_cur;
      if (wlast) begin
        total_r <= prod_low;
        tovf_r  <= povf;
        bad_r   <= bad_w;
        idx_r   <= IDXB'(n_r - NB'(1));
      end else begin
        w_r[idx_r + IDXB'(1)]   <= prod_low;
        ovf_r[idx_r + IDXB'(1)] <= povf;
        idx_r                   <= idx_r + IDXB'(1);
      end
    end else if (state_r == FS_DIV) begin
      rem_r   <= INDEX_BITS'(remx - dsel);
      dv_r    <= dsrc >> 2;
      digit_r <= digit_new;
      step_r  <= step_r + SB'(1);
      if (dlast) begin
        top_r[idx_r]  <= (digit_new == (radix - RADIX_BITS'(1)));
        zero_r[idx_r] <= (digit_new == '0);
        if (idx_r != '0) begin
          idx_r <= idx_r - IDXB'(1);
        end
      end
    end
  end

  assign in_ch.ready = in_ready;
  assign ent_node    = node_r;
  assign ent_ctl     = '{hex: hex_r, bad: bad_r};
  assign ent_lastp   = lastp_r;
  assign ent_top     = top_r;
  assign ent_zero    = zero_r;
  assign w_o         = w_r;
  assign rw_o        = rw_r;

endmodule

// ===== sv/tng_fifo.sv =====
// ----------------------------------------------------------------------------
// tng_fifo: short queue between the front and the back
// Holds classified nodes so that digit extraction and result output stall
// independently.
// ----------------------------------------------------------------------------
module tng_fifo
  import tng_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTRB = (QUEUE_DEPTH < 2) ? 1 : $clog2(QUEUE_DEPTH);
  localparam int CNTB = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_r [QUEUE_DEPTH];
  logic [PTRB-1:0]  wp_r;
  logic [PTRB-1:0]  rp_r;
  logic [CNTB-1:0]  cnt_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (cnt_r != CNTB'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PTRB'(QUEUE_DEPTH - 1)) ? '0 : wp_r + PTRB'(1);
      end
      if (do_pop) begin
        rp_r <= (rp_r == PTRB'(QUEUE_DEPTH - 1)) ? '0 : rp_r + PTRB'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNTB'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNTB'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

// ===== sv/tng_back.sv =====
// ----------------------------------------------------------------------------
// tng_back: neighbor result generation
// Walks the ports of the node at the head of the queue, one result per cycle
// while out_ch accepts, adding each port's signed place-value step to the node.
// ----------------------------------------------------------------------------
module tng_back
  import tng_pkg::*;
#(
  parameter int MAX_DIMS   = DEF_MAX_DIMS,
  parameter int INDEX_BITS = DEF_INDEX_BITS,
  localparam int D_SLOTS   = dim_slots(MAX_DIMS),
  localparam int PB        = port_cnt_bits(MAX_DIMS)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               ent_valid,
  output logic                               ent_ready,
  input  logic [INDEX_BITS-1:0]              ent_node,
  input  tng_ctl_t                           ent_ctl,
  input  logic [PB-1:0]                      ent_lastp,
  input  logic [D_SLOTS-1:0]                 ent_top,
  input  logic [D_SLOTS-1:0]                 ent_zero,
  input  logic [D_SLOTS-1:0][INDEX_BITS-1:0] w_i,
  input  logic [D_SLOTS-1:0][INDEX_BITS-1:0] rw_i,
  tng_out_if.source                          out_ch
);

  localparam int IDXB = $clog2(D_SLOTS);

  logic [PB-1:0]          p_r;
  logic                   ov_r;
  logic [PORT_BITS-1:0]   port_r;
  logic [INDEX_BITS-1:0]  nb_r;
  logic                   last_r;
  logic                   bad_r;

  logic [IDXB-1:0]        dj;
  logic [INDEX_BITS-1:0]  up_j;
  logic [INDEX_BITS-1:0]  dn_j;
  logic [INDEX_BITS-1:0]  up_x;
  logic [INDEX_BITS-1:0]  dn_x;
  logic [INDEX_BITS-1:0]  up_y;
  logic [INDEX_BITS-1:0]  dn_y;
  logic [INDEX_BITS-1:0]  hex_delta;
  logic [INDEX_BITS-1:0]  delta;
  logic                   adv;
  logic                   is_last;

  assign dj   = p_r[IDXB:1];
  assign up_j = ent_top[dj]  ? (INDEX_BITS'(0) - rw_i[dj]) : w_i[dj];
  assign dn_j = ent_zero[dj] ? rw_i[dj] : (INDEX_BITS'(0) - w_i[dj]);
  assign up_x = ent_top[0]   ? (INDEX_BITS'(0) - rw_i[0]) : w_i[0];
  assign dn_x = ent_zero[0]  ? rw_i[0] : (INDEX_BITS'(0) - w_i[0]);
  assign up_y = ent_top[1]   ? (INDEX_BITS'(0) - rw_i[1]) : w_i[1];
  assign dn_y = ent_zero[1]  ? rw_i[1] : (INDEX_BITS'(0) - w_i[1]);

  always_comb begin
    unique case (PORT_BITS'(p_r))
      HP_POS_Y:  hex_delta = up_y;
      HP_NEG_Y:  hex_delta = dn_y;
      HP_POS_X:  hex_delta = up_x;
      HP_NEG_X:  hex_delta = dn_x;
      HP_POS_XY: hex_delta = up_x + up_y;
      HP_NEG_XY: hex_delta = dn_x + dn_y;
      default:   hex_delta = '0;
    endcase
    if (ent_ctl.hex) begin
      delta = hex_delta;
    end else begin
      delta = p_r[0] ? dn_j : up_j;
    end
  end

  assign adv       = ent_valid && (!ov_r || out_ch.ready);
  assign is_last   = ent_ctl.bad || (p_r == ent_lastp);
  assign ent_ready = adv && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r  <= '0;
      ov_r <= 1'b0;
    end else begin
      if (adv) begin
        p_r  <= is_last ? '0 : p_r + PB'(1);
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      port_r <= ent_ctl.bad ? '0 : PORT_BITS'(p_r);
      nb_r   <= ent_ctl.bad ? '0 : ent_node + delta;
      last_r <= is_last;
      bad_r  <= ent_ctl.bad;
    end
  end

  assign out_ch.valid          = ov_r;
  assign out_ch.port           = port_r;
  assign out_ch.neighbor_index = nb_r;
  assign out_ch.last           = last_r;
  assign out_ch.bad_index      = bad_r;

endmodule

// ===== sv/torus_neighbor_generator_top.sv =====
// ----------------------------------------------------------------------------
// torus_neighbor_generator_top: neighbor list of one node of a k-ary n-cube
//
// Channel  Role    Payload                                   Transfer when
// in_ch    sink    node_index                                valid && ready
// out_ch   source  port, neighbor_index, last, bad_index     valid && ready
// APB      slave   radix, dimensions, hex_mode               psel && penable && pwrite
//
// The front extracts the digits of a node inside the network with a divider
// that retires two quotient bits per cycle; a node outside the network skips
// the divider. After reset or any register write, the first node waits while
// the place values are rebuilt. The back emits one result per cycle while the
// output channel accepts: 2*n for n dimensions, or six in hexagonal mode, per
// node, or a single result for a node outside the network.
// Reset clears all control state; there is no clearing pass.
// A two-entry queue between front and back lets either side stall alone.
// ----------------------------------------------------------------------------
module torus_neighbor_generator_top
  import tng_pkg::*;
#(
  parameter int MAX_DIMS   = DEF_MAX_DIMS,
  parameter int INDEX_BITS = DEF_INDEX_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  tng_in_if.sink                   in_ch,
  tng_out_if.source                out_ch,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  localparam int D_SLOTS = dim_slots(MAX_DIMS);
  localparam int PB      = port_cnt_bits(MAX_DIMS);
  localparam int EW      = $bits(tng_ctl_t) + PB + 2 * D_SLOTS + INDEX_BITS;

  logic [RADIX_BITS-1:0] radix_r;
  logic [DIMS_BITS-1:0]  dims_r;
  logic                  hex_r;
  logic                  cfg_wr;
  logic [1:0]            reg_idx;

  logic                               f_valid;
  logic                               f_ready;
  logic [INDEX_BITS-1:0]              f_node;
  tng_ctl_t                           f_ctl;
  logic [PB-1:0]                      f_lastp;
  logic [D_SLOTS-1:0]                 f_top;
  logic [D_SLOTS-1:0]                 f_zero;
  logic [D_SLOTS-1:0][INDEX_BITS-1:0] w;
  logic [D_SLOTS-1:0][INDEX_BITS-1:0] rw;

  logic                               b_valid;
  logic                               b_ready;
  logic [INDEX_BITS-1:0]              b_node;
  tng_ctl_t                           b_ctl;
  logic [PB-1:0]                      b_lastp;
  logic [D_SLOTS-1:0]                 b_top;
  logic [D_SLOTS-1:0]                 b_zero;

  logic [EW-1:0] q_in;
  logic [EW-1:0] q_out;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RST;
      dims_r  <= DIMS_RST;
      hex_r   <= HEX_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_RADIX: radix_r <= pwdata[RADIX_BITS-1:0];
        REG_DIMS:  dims_r  <= pwdata[DIMS_BITS-1:0];
        REG_HEX:   hex_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_RADIX: prdata = CFG_DATA_BITS'(radix_r);
      REG_DIMS:  prdata = CFG_DATA_BITS'(dims_r);
      REG_HEX:   prdata = CFG_DATA_BITS'(hex_r);
      default:   prdata = '0;
    endcase
  end

  tng_front #(
    .MAX_DIMS   (MAX_DIMS),
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .radix      (radix_r),
    .dimensions (dims_r),
    .hex_mode   (hex_r),
    .cfg_wr     (cfg_wr),
    .ent_valid  (f_valid),
    .ent_ready  (f_ready),
    .ent_node   (f_node),
    .ent_ctl    (f_ctl),
    .ent_lastp  (f_lastp),
    .ent_top    (f_top),
    .ent_zero   (f_zero),
    .w_o        (w),
    .rw_o       (rw)
  );

  assign q_in = {f_ctl, f_lastp, f_top, f_zero, f_node};

  tng_fifo #(
    .WIDTH (EW)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (q_in),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (q_out)
  );

  assign {b_ctl, b_lastp, b_top, b_zero, b_node} = q_out;

  tng_back #(
    .MAX_DIMS   (MAX_DIMS),
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ent_valid (b_valid),
    .ent_ready (b_ready),
    .ent_node  (b_node),
    .ent_ctl   (b_ctl),
    .ent_lastp (b_lastp),
    .ent_top   (b_top),
    .ent_zero  (b_zero),
    .w_i       (w),
    .rw_i      (rw),
    .out_ch    (out_ch)
  );

endmodule

// ===== tb/torus_neighbor_generator_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// torus_neighbor_generator_top_test: neighbor list check of the torus generator
// Sends node indices and predicts every neighbor transfer from its own model
// of the mixed-radix torus and hexagonal layouts. Results are checked in order.
// The network settings are changed over the APB port between phases and read
// back, and random idling and stalling run on both channels.
// ----------------------------------------------------------------------------
module torus_neighbor_generator_top_test
  import tng_pkg::*;
();

  localparam int MAX_DIMS        = DEF_MAX_DIMS;
  localparam int INDEX_BITS      = DEF_INDEX_BITS;
  localparam int DIGIT_SLOTS     = 8;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 36;
  localparam int DRAIN_CYCLES    = 40;

  typedef struct packed {
    logic [PORT_BITS-1:0]  port;
    logic [INDEX_BITS-1:0] neighbor_index;
    logic                  last;
    logic                  bad_index;
  } neighbor_t;

  logic                     clk;
  logic                     rst_n;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [CFG_ADDR_BITS-1:0] paddr;
  logic [CFG_DATA_BITS-1:0] pwdata;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic                     pready;

  tng_in_if  #(.INDEX_BITS(INDEX_BITS)) in_ch ();
  tng_out_if #(.INDEX_BITS(INDEX_BITS)) out_ch ();

  logic [INDEX_BITS-1:0] node_queue[$];
  neighbor_t             neighbor_q[$];

  logic [RADIX_BITS-1:0] cfg_radix;
  logic [DIMS_BITS-1:0]  cfg_dims;
  logic                  cfg_hex;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatches;

  torus_neighbor_generator_top #(
    .MAX_DIMS  (MAX_DIMS),
    .INDEX_BITS(INDEX_BITS)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int unsigned active_dims();
    if (cfg_hex) return 2;
    if (cfg_dims == 0) return 1;
    if (cfg_dims > MAX_DIMS) return MAX_DIMS;
    return cfg_dims;
  endfunction

  function automatic longint unsigned network_span();
    longint unsigned span;
    span = 1;
    for (int j = 0; j < active_dims(); j++) span *= cfg_radix;
    return span;
  endfunction

  function automatic longint unsigned ring_up(input longint unsigned d,
                                              input longint unsigned r);
    return (d + 1 >= r) ? 0 : d + 1;
  endfunction

  function automatic longint unsigned ring_down(input longint unsigned d,
                                                input longint unsigned r);
    return (d == 0) ? r - 1 : d - 1;
  endfunction

  function automatic logic [INDEX_BITS-1:0] pack_digits(
      input longint unsigned digits[DIGIT_SLOTS], input int unsigned n,
      input longint unsigned r);
    longint unsigned acc;
    longint unsigned weight;
    acc    = 0;
    weight = 1;
    for (int j = 0; j < n; j++) begin
      acc    += digits[j] * weight;
      weight *= r;
    end
    return acc[INDEX_BITS-1:0];
  endfunction

  function automatic void queue_neighbor(input logic [PORT_BITS-1:0] port,
                                         input logic [INDEX_BITS-1:0] idx,
                                         input logic last, input logic bad);
    neighbor_t nb;
    nb.port           = port;
    nb.neighbor_index = idx;
    nb.last           = last;
    nb.bad_index      = bad;
    neighbor_q.push_back(nb);
  endfunction

  function automatic void predict_neighbors(input logic [INDEX_BITS-1:0] node);
    longint unsigned r;
    longint unsigned rest;
    longint unsigned digit[DIGIT_SLOTS];
    longint unsigned moved[DIGIT_SLOTS];
    int unsigned     n;
    r = cfg_radix;
    n = active_dims();
    if (r == 0 || node >= network_span()) begin
      queue_neighbor('0, '0, 1'b1, 1'b1);
      return;
    end
    rest = node;
    for (int j = 0; j < DIGIT_SLOTS; j++) begin
      digit[j] = 0;
      moved[j] = 0;
    end
    for (int j = 0; j < n; j++) begin
      digit[j] = rest % r;
      rest     = rest / r;
    end
    if (cfg_hex) begin
      for (int p = HP_POS_Y; p <= HEX_LAST_PORT; p++) begin
        moved[0] = digit[0];
        moved[1] = digit[1];
        case (PORT_BITS'(p))
          HP_POS_Y:  moved[1] = ring_up(digit[1], r);
          HP_NEG_Y:  moved[1] = ring_down(digit[1], r);
          HP_POS_X:  moved[0] = ring_up(digit[0], r);
          HP_NEG_X:  moved[0] = ring_down(digit[0], r);
          HP_POS_XY: begin
            moved[0] = ring_up(digit[0], r);
            moved[1] = ring_up(digit[1], r);
          end
          HP_NEG_XY: begin
            moved[0] = ring_down(digit[0], r);
            moved[1] = ring_down(digit[1], r);
          end
          default: ;
        endcase
        queue_neighbor(PORT_BITS'(p), pack_digits(moved, 2, r),
                       PORT_BITS'(p) == HEX_LAST_PORT, 1'b0);
      end
      return;
    end
    for (int j = 0; j < n; j++) begin
      for (int i = 0; i < n; i++) moved[i] = digit[i];
      moved[j] = ring_up(digit[j], r);
      queue_neighbor(PORT_BITS'(2 * j), pack_digits(moved, n, r), 1'b0, 1'b0);
      moved[j] = ring_down(digit[j], r);
      queue_neighbor(PORT_BITS'(2 * j + 1), pack_digits(moved, n, r),
                     j == n - 1, 1'b0);
    end
  endfunction

  function automatic logic [INDEX_BITS-1:0] pick_node();
    longint unsigned span;
    int unsigned     roll;
    span = network_span();
    roll = $urandom_range(99);
    if (span == 0 || roll < 8) return INDEX_BITS'($urandom_range(65535));
    if (roll < 12) return (span > 65536) ? 16'hffff : INDEX_BITS'(span - 1);
    if (roll < 15 && span <= 65535) return INDEX_BITS'(span);
    if (span > 65536) return INDEX_BITS'($urandom_range(65535));
    return INDEX_BITS'($urandom_range(32'(span - 1)));
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (node_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid      <= 1'b1;
        in_ch.node_index <= node_queue.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    neighbor_t want;
    neighbor_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.port           = out_ch.port;
      got.neighbor_index = out_ch.neighbor_index;
      got.last           = out_ch.last;
      got.bad_index      = out_ch.bad_index;
      if (neighbor_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transfer: port %0d index %0d last %b bad %b",
                   got.port, got.neighbor_index, got.last, got.bad_index);
      end else begin
        want = neighbor_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected port %0d index %0d last %b bad %b, %s",
                     want.port, want.neighbor_index, want.last, want.bad_index,
                     $sformatf("got port %0d index %0d last %b bad %b",
                               got.port, got.neighbor_index, got.last,
                               got.bad_index));
        end
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) predict_neighbors(in_ch.node_index);
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (node_queue.size() != 0 || in_ch.valid || neighbor_q.size() != 0);
  endtask

  task automatic cfg_write(input logic [1:0] reg_idx,
                           input logic [CFG_DATA_BITS-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_BITS'(reg_idx) << 2;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (reg_idx)
      REG_RADIX: cfg_radix = value[RADIX_BITS-1:0];
      REG_DIMS:  cfg_dims  = value[DIMS_BITS-1:0];
      REG_HEX:   cfg_hex   = value[0];
      default: ;
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== value) begin
      mismatches++;
      if (mismatches <= 10)
        $display("register %0d read back %h, expected %h", reg_idx, prdata, value);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_setting(input int unsigned r, input int unsigned d,
                               input bit h);
    wait_drained();
    cfg_write(REG_RADIX, CFG_DATA_BITS'(r));
    cfg_write(REG_DIMS, CFG_DATA_BITS'(d));
    cfg_write(REG_HEX, CFG_DATA_BITS'(h));
    @(negedge clk);
  endtask

  task automatic run_phase(input int unsigned r, input int unsigned d,
                           input bit h, input int unsigned mode);
    apply_setting(r, d, h);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
      default: begin send_idle_pct = 24; recv_stall_pct = 24; end
    endcase
    for (int k = 0; k < ITEMS_PER_PHASE / 2; k++) node_queue.push_back(pick_node());
    wait_drained();
    for (int k = 0; k < ITEMS_PER_PHASE / 2; k++) node_queue.push_back(pick_node());
  endtask

  initial begin
    int unsigned phase_radix[PHASES];
    int unsigned phase_dims[PHASES];
    bit          phase_hex[PHASES];
    phase_radix = '{255, 2, 16, 255, 2, 1, 0, 0, 0, 0, 3, 0};
    phase_dims  = '{4, 4, 2, 1, 1, 2, 3, 0, 0, 0, 6, 0};
    phase_hex   = '{0, 0, 0, 1, 1, 0, 0, 0, 1, 0, 0, 0};
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.node_index = '0;
    out_ch.ready     = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    cfg_radix        = RADIX_RST;
    cfg_dims         = DIMS_RST;
    cfg_hex          = HEX_RST;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    mismatches       = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Settings left at their reset values.
    node_queue.push_back(16'd0);
    node_queue.push_back(16'd15);
    node_queue.push_back(16'd16);
    node_queue.push_back(16'hffff);
    node_queue.push_back(16'd6);
    // A network wider than the index cuts the neighbor indices.
    apply_setting(255, 4, 0);
    node_queue.push_back(16'd0);
    node_queue.push_back(16'hffff);
    node_queue.push_back(16'h7fff);
    apply_setting(2, 1, 0);
    node_queue.push_back(16'd0);
    node_queue.push_back(16'd1);
    node_queue.push_back(16'd2);
    // With a single node per ring every neighbor is the node itself.
    apply_setting(1, 3, 0);
    node_queue.push_back(16'd0);
    node_queue.push_back(16'd1);
    // An empty network rejects every index.
    apply_setting(0, 2, 0);
    node_queue.push_back(16'd0);
    node_queue.push_back(16'd7);
    apply_setting(3, 0, 0);
    node_queue.push_back(16'd0);
    node_queue.push_back(16'd2);
    node_queue.push_back(16'd3);
    apply_setting(3, 7, 0);
    node_queue.push_back(16'd80);
    node_queue.push_back(16'd81);
    // Hexagonal mode ignores the dimension count.
    apply_setting(255, 1, 1);
    node_queue.push_back(16'd0);
    node_queue.push_back(16'd65024);
    node_queue.push_back(16'd65025);
    apply_setting(2, 4, 1);
    node_queue.push_back(16'd0);
    node_queue.push_back(16'd3);
    node_queue.push_back(16'd4);

    for (int p = 0; p < PHASES; p++) begin
      if (phase_radix[p] == 0 && p != 6) phase_radix[p] = $urandom_range(255, 2);
      if (phase_dims[p] == 0 && p != 9) phase_dims[p] = $urandom_range(MAX_DIMS, 1);
      run_phase(phase_radix[p], phase_dims[p], phase_hex[p], p % 4);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
